@@ hdl/gfel_pkg.sv @@
// ---------------------------------------------------------------------------
// gfel_pkg: shared types and constants for the GF(p^n) ElGamal encryptor
// Holds the polynomial type, register map codes and sequencer state types.
// ---------------------------------------------------------------------------
package gfel_pkg;

    localparam int MaxDeg   = 4;
    localparam int CoefBits = 16;
    localparam int BufLen   = 2 * MaxDeg;
    localparam int ExpBits  = 16;

    typedef logic [CoefBits-1:0]              coef_t;
    typedef logic [MaxDeg-1:0][CoefBits-1:0]  poly_t;
    typedef logic [$clog2(BufLen)-1:0]        buf_idx_t;
    typedef logic [$clog2(MaxDeg)-1:0]        coef_idx_t;
    typedef logic [$clog2(MaxDeg+1)-1:0]      deg_t;
    typedef logic [$clog2(ExpBits)-1:0]       ebit_t;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t RegPrime  = 3'd0;
    localparam reg_idx_t RegDegree = 3'd1;
    localparam reg_idx_t RegTail   = 3'd2;
    localparam reg_idx_t RegGen    = 3'd3;
    localparam reg_idx_t RegPubKey = 3'd4;

    localparam logic [15:0] PrimeReset = 16'd65521;

    // Sequencer for one whole transaction.
    typedef enum logic [3:0] {
        J_IDLE,
        J_LTAIL,
        J_LGEN,
        J_LKEY,
        J_LMSG,
        J_SQR,
        J_PMUL,
        J_FMUL,
        J_OUT
    } job_state_t;

    // Polynomial product / load engine around the shared serial multiplier.
    typedef enum logic [2:0] {
        E_IDLE,
        E_CLEAR,
        E_LOAD,
        E_MAC,
        E_ADD,
        E_FRD,
        E_DONE
    } eng_state_t;

    typedef struct packed {
        logic launch;
        logic mul_mode;
        logic fold_en;
    } eng_cmd_t;

endpackage

@@ hdl/gf_pn_elgamal_encrypt_unit.sv @@
// ---------------------------------------------------------------------------
// gf_pn_elgamal_encrypt_unit: ElGamal encryption over GF(p)[x]/(h)
// Computes c1 = g^e and c2 = m * k^e with a bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// Usage. Program prime_modulus, field_degree, reduction_tail, generator_poly
// and public_key_poly through the APB port (64-bit data, register i at byte
// address 8*i) while the block is idle. An input transaction carries the four
// message coefficients and the exponent e; it is taken when in_valid is high
// and in_stall is low. The block holds in_stall high from acceptance until its
// single result transaction has been taken.
// Operation. All arithmetic runs on one multiply-accumulate unit that consumes
// one multiplier bit per cycle: a modular multiply-add loads its operands,
// shifts through the multiplier bits and adds the product into the buffer. A
// polynomial product of degree n takes (2n*n - n) such steps plus fold
// bookkeeping and set-up; loading the tail, g, k and m takes 4 steps each,
// with folding for g, k and m. In all, the work is 4 loads and
// 33 + 2*popcount(e) products (16 squarings and popcount(e) multiplies per
// power, then the product with m). Throughput is one transaction at a time;
// the next one can be taken in the cycle after the result leaves.
// The result stays on first_coef* and second_coef* with out_valid high for as
// long as out_stall is high. Reset returns the registers to their reset values
// and abandons any transaction in progress.
// ---------------------------------------------------------------------------
module gf_pn_elgamal_encrypt_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] msg_coef0,
    input  logic [15:0] msg_coef1,
    input  logic [15:0] msg_coef2,
    input  logic [15:0] msg_coef3,
    input  logic [15:0] ephemeral_exponent,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] first_coef0,
    output logic [15:0] first_coef1,
    output logic [15:0] first_coef2,
    output logic [15:0] first_coef3,
    output logic [15:0] second_coef0,
    output logic [15:0] second_coef1,
    output logic [15:0] second_coef2,
    output logic [15:0] second_coef3
);

    // Configuration registers
    logic [15:0] prime_reg;
    logic [2:0]  degree_reg;
    logic [63:0] tail_cfg_reg;
    logic [63:0] gen_cfg_reg;
    logic [63:0] key_cfg_reg;

    // Transaction state
    gfel_pkg::job_state_t job_reg, job_next;
    logic                 issued_reg;
    logic                 key_pass_reg;
    gfel_pkg::ebit_t      ebit_reg;
    logic [15:0]          exp_reg;
    gfel_pkg::poly_t      msg_raw_reg;
    logic [15:0]          p_reg;
    gfel_pkg::deg_t       n_reg;
    logic                 one_reg;

    gfel_pkg::poly_t t_reg, g_reg, k_reg, m_reg, r_reg, c1_reg;

    // Engine
    gfel_pkg::eng_state_t eng_reg, eng_next;
    gfel_pkg::eng_cmd_t   cmd;
    logic                 mul_mode_reg;
    logic                 fold_en_reg;
    logic                 in_fold_reg;
    gfel_pkg::poly_t      opa_reg, opb_reg;
    gfel_pkg::poly_t      opa_src, opb_src;
    gfel_pkg::coef_idx_t  ci_reg, cj_reg;
    gfel_pkg::buf_idx_t   fi_reg;
    logic [15:0]          fv_reg;
    logic [15:0]          buf_reg [gfel_pkg::BufLen];

    // Serial multiplier
    logic [15:0] sh_reg;
    logic [15:0] bb_reg;
    logic [15:0] acc_reg;
    logic [3:0]  bitc_reg;

    logic                 eng_done;
    logic                 cfg_wr;
    gfel_pkg::reg_idx_t   cfg_idx;
    logic [15:0]          p_eff;
    gfel_pkg::deg_t       n_eff;
    gfel_pkg::poly_t      res_poly;
    gfel_pkg::poly_t      one_poly;
    gfel_pkg::buf_idx_t   dst_idx;
    gfel_pkg::buf_idx_t   rd_idx;
    gfel_pkg::buf_idx_t   fold_top;
    gfel_pkg::buf_idx_t   n_idx;
    gfel_pkg::coef_idx_t  n_last;
    logic [15:0]          a_sel, b_sel;
    logic [17:0]          step_sum, step_red;
    logic [16:0]          add_sum, add_red;
    logic                 exp_bit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        case (cfg_idx)
            gfel_pkg::RegPrime:  prdata = {48'd0, prime_reg};
            gfel_pkg::RegDegree: prdata = {61'd0, degree_reg};
            gfel_pkg::RegTail:   prdata = tail_cfg_reg;
            gfel_pkg::RegGen:    prdata = gen_cfg_reg;
            gfel_pkg::RegPubKey: prdata = key_cfg_reg;
            default:             prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg    <= gfel_pkg::PrimeReset;
            degree_reg   <= 3'd1;
            tail_cfg_reg <= 64'd0;
            gen_cfg_reg  <= 64'd1;
            key_cfg_reg  <= 64'd1;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                gfel_pkg::RegPrime:  prime_reg    <= pwdata[15:0];
                gfel_pkg::RegDegree: degree_reg   <= pwdata[2:0];
                gfel_pkg::RegTail:   tail_cfg_reg <= pwdata;
                gfel_pkg::RegGen:    gen_cfg_reg  <= pwdata;
                gfel_pkg::RegPubKey: key_cfg_reg  <= pwdata;
                default:             ;
            endcase
        end
    end

    // A modulus below two behaves as one; the degree is clamped to 1..MaxDeg.
    assign p_eff = (prime_reg < 16'd2) ? 16'd1 : prime_reg;
    always_comb
    begin
        if (degree_reg == 3'd0)
            n_eff = gfel_pkg::deg_t'(1);
        else if (degree_reg > 3'(gfel_pkg::MaxDeg))
            n_eff = gfel_pkg::deg_t'(gfel_pkg::MaxDeg);
        else
            n_eff = gfel_pkg::deg_t'(degree_reg);
    end

    always_comb
    begin
        one_poly    = '0;
        one_poly[0] = {15'd0, one_reg};
        for (int k = 0; k < gfel_pkg::MaxDeg; k++)
            res_poly[k] = (k < n_reg) ? buf_reg[k] : 16'd0;
    end

    assign eng_done = (eng_reg == gfel_pkg::E_DONE);
    assign exp_bit  = exp_reg[ebit_reg];

    // ---------------- transaction sequencer ----------------
    always_comb
    begin
        job_next = job_reg;
        case (job_reg)
            gfel_pkg::J_IDLE:
                if (in_valid)
                    job_next = gfel_pkg::J_LTAIL;
            gfel_pkg::J_LTAIL:
                if (eng_done)
                    job_next = gfel_pkg::J_LGEN;
            gfel_pkg::J_LGEN:
                if (eng_done)
                    job_next = gfel_pkg::J_LKEY;
            gfel_pkg::J_LKEY:
                if (eng_done)
                    job_next = gfel_pkg::J_LMSG;
            gfel_pkg::J_LMSG:
                if (eng_done)
                    job_next = gfel_pkg::J_SQR;
            gfel_pkg::J_SQR, gfel_pkg::J_PMUL:
                if (eng_done)
                begin
                    if (job_reg == gfel_pkg::J_SQR && exp_bit)
                        job_next = gfel_pkg::J_PMUL;
                    else if (ebit_reg != '0 || !key_pass_reg)
                        job_next = gfel_pkg::J_SQR;
                    else
                        job_next = gfel_pkg::J_FMUL;
                end
            gfel_pkg::J_FMUL:
                if (eng_done)
                    job_next = gfel_pkg::J_OUT;
            gfel_pkg::J_OUT:
                if (!out_stall)
                    job_next = gfel_pkg::J_IDLE;
            default:
                job_next = gfel_pkg::J_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        opa_src = r_reg;
        opb_src = r_reg;
        cmd.launch = (job_reg != gfel_pkg::J_IDLE) && (job_reg != gfel_pkg::J_OUT)
                     && (eng_reg == gfel_pkg::E_IDLE) && !issued_reg;
        case (job_reg)
            gfel_pkg::J_LTAIL:
                opa_src = gfel_pkg::poly_t'(tail_cfg_reg);
            gfel_pkg::J_LGEN:
            begin
                opa_src     = gfel_pkg::poly_t'(gen_cfg_reg);
                cmd.fold_en = 1'b1;
            end
            gfel_pkg::J_LKEY:
            begin
                opa_src     = gfel_pkg::poly_t'(key_cfg_reg);
                cmd.fold_en = 1'b1;
            end
            gfel_pkg::J_LMSG:
            begin
                opa_src     = msg_raw_reg;
                cmd.fold_en = 1'b1;
            end
            gfel_pkg::J_SQR:
            begin
                cmd.mul_mode = 1'b1;
                cmd.fold_en  = 1'b1;
            end
            gfel_pkg::J_PMUL:
            begin
                opb_src      = key_pass_reg ? k_reg : g_reg;
                cmd.mul_mode = 1'b1;
                cmd.fold_en  = 1'b1;
            end
            gfel_pkg::J_FMUL:
            begin
                opa_src      = m_reg;
                cmd.mul_mode = 1'b1;
                cmd.fold_en  = 1'b1;
            end
            default:
                cmd.launch = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg      <= gfel_pkg::J_IDLE;
            issued_reg   <= 1'b0;
            key_pass_reg <= 1'b0;
            ebit_reg     <= '0;
        end
        else
        begin
            job_reg <= job_next;
            if (cmd.launch)
                issued_reg <= 1'b1;
            else if (eng_done)
                issued_reg <= 1'b0;
            if (job_reg == gfel_pkg::J_IDLE)
                key_pass_reg <= 1'b0;
            if (eng_done)
            begin
                if (job_reg == gfel_pkg::J_LMSG)
                    ebit_reg <= gfel_pkg::ebit_t'(gfel_pkg::ExpBits - 1);
                else if (job_next == gfel_pkg::J_SQR)
                begin
                    if (ebit_reg == '0)
                    begin
                        ebit_reg     <= gfel_pkg::ebit_t'(gfel_pkg::ExpBits - 1);
                        key_pass_reg <= 1'b1;
                    end
                    else
                        ebit_reg <= ebit_reg - 1'b1;
                end
            end
        end
    end

    // Transaction payload and polynomial registers.
    always_ff @(posedge clk)
    begin
        if (job_reg == gfel_pkg::J_IDLE && in_valid)
        begin
            msg_raw_reg <= {msg_coef3, msg_coef2, msg_coef1, msg_coef0};
            exp_reg     <= ephemeral_exponent;
            p_reg       <= p_eff;
            n_reg       <= n_eff;
            one_reg     <= (p_eff != 16'd1);
        end
        if (eng_done)
        begin
            case (job_reg)
                gfel_pkg::J_LTAIL: t_reg <= res_poly;
                gfel_pkg::J_LGEN:  g_reg <= res_poly;
                gfel_pkg::J_LKEY:  k_reg <= res_poly;
                gfel_pkg::J_LMSG:
                begin
                    m_reg <= res_poly;
                    r_reg <= one_poly;
                end
                gfel_pkg::J_SQR, gfel_pkg::J_PMUL:
                begin
                    // The end of the first power hands g^e over and restarts at one.
                    if (job_next == gfel_pkg::J_SQR && ebit_reg == '0)
                    begin
                        c1_reg <= res_poly;
                        r_reg  <= one_poly;
                    end
                    else
                        r_reg <= res_poly;
                end
                gfel_pkg::J_FMUL:  r_reg <= res_poly;
                default:           ;
            endcase
        end
    end

    assign in_stall  = (job_reg != gfel_pkg::J_IDLE);
    assign out_valid = (job_reg == gfel_pkg::J_OUT);

    assign first_coef0  = c1_reg[0];
    assign first_coef1  = c1_reg[1];
    assign first_coef2  = c1_reg[2];
    assign first_coef3  = c1_reg[3];
    assign second_coef0 = r_reg[0];
    assign second_coef1 = r_reg[1];
    assign second_coef2 = r_reg[2];
    assign second_coef3 = r_reg[3];

    // ---------------- product engine ----------------
    assign n_idx    = gfel_pkg::buf_idx_t'(n_reg);
    assign n_last   = gfel_pkg::coef_idx_t'(n_reg - 1'b1);
    assign fold_top = mul_mode_reg ? gfel_pkg::buf_idx_t'({n_idx, 1'b0} - 2'd2)
                                   : gfel_pkg::buf_idx_t'(gfel_pkg::MaxDeg - 1);

    assign dst_idx = in_fold_reg
                   ? gfel_pkg::buf_idx_t'(fi_reg - n_idx + gfel_pkg::buf_idx_t'(cj_reg))
                   : gfel_pkg::buf_idx_t'(ci_reg) + gfel_pkg::buf_idx_t'(cj_reg);
    assign rd_idx  = (eng_reg == gfel_pkg::E_FRD) ? fi_reg : dst_idx;

    assign a_sel = in_fold_reg ? fv_reg : opa_reg[ci_reg];
    always_comb
    begin
        if (in_fold_reg)
            b_sel = t_reg[cj_reg];
        else if (mul_mode_reg)
            b_sel = opb_reg[cj_reg];
        else
            b_sel = {15'd0, one_reg};
    end

    // One multiplier bit per cycle: acc = 2*acc + bit*b, kept below p.
    always_comb
    begin
        step_sum = {1'b0, acc_reg, 1'b0} + (sh_reg[15] ? {2'b00, bb_reg} : 18'd0);
        if (step_sum >= {1'b0, p_reg, 1'b0})
            step_red = step_sum - {1'b0, p_reg, 1'b0};
        else if (step_sum >= {2'b00, p_reg})
            step_red = step_sum - {2'b00, p_reg};
        else
            step_red = step_sum;
        add_sum = {1'b0, buf_reg[rd_idx]} + {1'b0, acc_reg};
        if (add_sum >= {1'b0, p_reg})
            add_red = add_sum - {1'b0, p_reg};
        else
            add_red = add_sum;
    end

    always_comb
    begin
        eng_next = eng_reg;
        case (eng_reg)
            gfel_pkg::E_IDLE:
                if (cmd.launch)
                    eng_next = gfel_pkg::E_CLEAR;
            gfel_pkg::E_CLEAR:
                eng_next = gfel_pkg::E_LOAD;
            gfel_pkg::E_LOAD:
                eng_next = gfel_pkg::E_MAC;
            gfel_pkg::E_MAC:
                if (bitc_reg == 4'd15)
                    eng_next = gfel_pkg::E_ADD;
            gfel_pkg::E_ADD:
            begin
                if (in_fold_reg)
                begin
                    if (cj_reg != n_last)
                        eng_next = gfel_pkg::E_LOAD;
                    else if (fi_reg - 1'b1 >= n_idx)
                        eng_next = gfel_pkg::E_FRD;
                    else
                        eng_next = gfel_pkg::E_DONE;
                end
                else if (mul_mode_reg && (cj_reg != n_last || ci_reg != n_last))
                    eng_next = gfel_pkg::E_LOAD;
                else if (!mul_mode_reg
                         && ci_reg != gfel_pkg::coef_idx_t'(gfel_pkg::MaxDeg - 1))
                    eng_next = gfel_pkg::E_LOAD;
                else if (fold_en_reg && fold_top >= n_idx)
                    eng_next = gfel_pkg::E_FRD;
                else
                    eng_next = gfel_pkg::E_DONE;
            end
            gfel_pkg::E_FRD:
                eng_next = gfel_pkg::E_LOAD;
            gfel_pkg::E_DONE:
                eng_next = gfel_pkg::E_IDLE;
            default:
                eng_next = gfel_pkg::E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eng_reg <= gfel_pkg::E_IDLE;
        else
            eng_reg <= eng_next;
    end

    always_ff @(posedge clk)
    begin
        case (eng_reg)
            gfel_pkg::E_IDLE:
                if (cmd.launch)
                begin
                    opa_reg      <= opa_src;
                    opb_reg      <= opb_src;
                    mul_mode_reg <= cmd.mul_mode;
                    fold_en_reg  <= cmd.fold_en;
                end
            gfel_pkg::E_CLEAR:
            begin
                for (int k = 0; k < gfel_pkg::BufLen; k++)
                    buf_reg[k] <= 16'd0;
                ci_reg      <= '0;
                cj_reg      <= '0;
                in_fold_reg <= 1'b0;
            end
            gfel_pkg::E_LOAD:
            begin
                sh_reg   <= a_sel;
                bb_reg   <= b_sel;
                acc_reg  <= 16'd0;
                bitc_reg <= 4'd0;
            end
            gfel_pkg::E_MAC:
            begin
                acc_reg  <= step_red[15:0];
                sh_reg   <= {sh_reg[14:0], 1'b0};
                bitc_reg <= bitc_reg + 1'b1;
            end
            gfel_pkg::E_ADD:
            begin
                buf_reg[dst_idx] <= add_red[15:0];
                if (in_fold_reg)
                begin
                    cj_reg <= cj_reg + 1'b1;
                    if (cj_reg == n_last)
                        fi_reg <= fi_reg - 1'b1;
                end
                else if (mul_mode_reg)
                begin
                    if (cj_reg != n_last)
                        cj_reg <= cj_reg + 1'b1;
                    else
                    begin
                        cj_reg <= '0;
                        ci_reg <= ci_reg + 1'b1;
                    end
                    fi_reg <= fold_top;
                end
                else
                begin
                    ci_reg <= ci_reg + 1'b1;
                    fi_reg <= fold_top;
                end
            end
            gfel_pkg::E_FRD:
            begin
                // Fold the top coefficient down through x^n = sum t_j x^j.
                fv_reg          <= buf_reg[rd_idx];
                buf_reg[fi_reg] <= 16'd0;
                cj_reg          <= '0;
                in_fold_reg     <= 1'b1;
            end
            default:
                ;
        endcase
    end

endmodule

@@ hdl/gfel_checker.sv @@
// ---------------------------------------------------------------------------
// gfel_checker: port-level checks for the GF(p^n) ElGamal encryptor
// Watches the handshakes of both channels and the one-at-a-time behaviour.
// ---------------------------------------------------------------------------
module gfel_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] first_coef0,
    input logic [15:0] second_coef0
);

    // A result being held must stay offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(first_coef0) && $stable(second_coef0))
        else $error("stalled result changed");

    // Once a transaction is taken, no other is taken until its result leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

endmodule

bind gf_pn_elgamal_encrypt_unit gfel_checker u_gfel_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_coef0  (first_coef0),
    .second_coef0 (second_coef0)
);

@@ tb/sv/gf_pn_elgamal_encrypt_unit_tb.sv @@
// ---------------------------------------------------------------------------
// gf_pn_elgamal_encrypt_unit_tb: self-checking bench for the ElGamal encryptor
// Programs the field, generator and key over APB, sends message transactions
// and compares c1 = g^e and c2 = m * k^e against a polynomial-arithmetic
// predictor, with random idling on both channels.
// ---------------------------------------------------------------------------
module gf_pn_elgamal_encrypt_unit_tb;

    localparam int LimitCycles = 50000000;
    localparam int ItemTarget  = 290;
    localparam int CalmItems   = 250;

    typedef logic [63:0] pbuf_t [8];

    typedef struct packed {
        logic [3:0][15:0] c1;
        logic [3:0][15:0] c2;
    } cipher_t;

    typedef struct {
        logic [15:0] m0, m1, m2, m3, e;
        bit          typed;
        cipher_t     c;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] msg_coef0 = '0, msg_coef1 = '0, msg_coef2 = '0, msg_coef3 = '0;
    logic [15:0] ephemeral_exponent = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] first_coef0, first_coef1, first_coef2, first_coef3;
    logic [15:0] second_coef0, second_coef1, second_coef2, second_coef3;

    gf_pn_elgamal_encrypt_unit i_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Register shadow and per-transaction working values of the predictor.
    logic [15:0] sh_prime = gfel_pkg::PrimeReset;
    logic [2:0]  sh_degree = 3'd1;
    logic [63:0] sh_tail = 64'd0, sh_gen = 64'd1, sh_key = 64'd1;
    logic [63:0] wk_mod;
    int          wk_n;
    logic [63:0] wk_tail [4];

    cipher_t pending_cipher [$];
    int      errors = 0;
    int      sent = 0;
    int      cycles = 0;
    bit      idle_on = 1'b1;
    int      stall_left = 0;

    function automatic pbuf_t fold_buf(pbuf_t b, int len);
        logic [63:0] v;
        int d;
        for (int i = len - 1; i >= wk_n; i--)
        begin
            v = b[i];
            for (int j = 0; j < wk_n; j++)
            begin
                d = i - wk_n + j;
                b[d] = (b[d] + v * wk_tail[j]) % wk_mod;
            end
            b[i] = 0;
        end
        return b;
    endfunction

    function automatic pbuf_t load_poly(logic [63:0] packed_val);
        pbuf_t b;
        for (int i = 0; i < 8; i++)
            b[i] = 0;
        for (int i = 0; i < 4; i++)
            b[i] = {48'd0, packed_val[16*i +: 16]} % wk_mod;
        return fold_buf(b, 4);
    endfunction

    function automatic pbuf_t poly_mul(pbuf_t a, pbuf_t b);
        pbuf_t c;
        for (int i = 0; i < 8; i++)
            c[i] = 0;
        for (int i = 0; i < wk_n; i++)
            for (int j = 0; j < wk_n; j++)
                c[i+j] = (c[i+j] + a[i] * b[j]) % wk_mod;
        return fold_buf(c, 2 * wk_n - 1);
    endfunction

    function automatic pbuf_t poly_pow(pbuf_t base, logic [15:0] e);
        pbuf_t r;
        for (int i = 0; i < 8; i++)
            r[i] = 0;
        r[0] = 64'd1 % wk_mod;
        for (int bi = 15; bi >= 0; bi--)
        begin
            r = poly_mul(r, r);
            if (e[bi])
                r = poly_mul(r, base);
        end
        return r;
    endfunction

    function automatic cipher_t encrypt_poly(logic [15:0] m0, logic [15:0] m1,
                                             logic [15:0] m2, logic [15:0] m3,
                                             logic [15:0] e);
        pbuf_t g, k, m, c1, c2;
        cipher_t res;
        wk_mod = (sh_prime < 2) ? 64'd1 : {48'd0, sh_prime};
        wk_n = (sh_degree == 0) ? 1
             : (sh_degree > gfel_pkg::MaxDeg) ? gfel_pkg::MaxDeg : int'(sh_degree);
        for (int i = 0; i < 4; i++)
            wk_tail[i] = {48'd0, sh_tail[16*i +: 16]} % wk_mod;
        g = load_poly(sh_gen);
        k = load_poly(sh_key);
        m = load_poly({m3, m2, m1, m0});
        c1 = poly_pow(g, e);
        c2 = poly_mul(m, poly_pow(k, e));
        for (int i = 0; i < 4; i++)
        begin
            res.c1[i] = c1[i][15:0];
            res.c2[i] = c2[i][15:0];
        end
        return res;
    endfunction

    task automatic apb_write(gfel_pkg::reg_idx_t idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            gfel_pkg::RegPrime:  sh_prime = val[15:0];
            gfel_pkg::RegDegree: sh_degree = val[2:0];
            gfel_pkg::RegTail:   sh_tail = val;
            gfel_pkg::RegGen:    sh_gen = val;
            gfel_pkg::RegPubKey: sh_key = val;
            default: ;
        endcase
    endtask

    // Caller sits at a rising edge; returns at the edge of acceptance or after a gap.
    task automatic send_msg(logic [15:0] m0, logic [15:0] m1, logic [15:0] m2,
                            logic [15:0] m3, logic [15:0] e, bit typed, cipher_t c);
        cipher_t exp_c;
        in_valid <= 1'b1;
        msg_coef0 <= m0;
        msg_coef1 <= m1;
        msg_coef2 <= m2;
        msg_coef3 <= m3;
        ephemeral_exponent <= e;
        do
            @(posedge clk);
        while (in_stall);
        exp_c = typed ? c : encrypt_poly(m0, m1, m2, m3, e);
        pending_cipher = {pending_cipher, exp_c};
        sent++;
        if (sent >= CalmItems)
            idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_cipher.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_poly();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] rand_prime();
        logic [15:0] primes [8] = '{16'd2, 16'd3, 16'd7, 16'd251, 16'd257,
                                    16'd65521, 16'd65519, 16'd65497};
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return primes[$urandom_range(0, 7)];
    endfunction

    // Output checker.
    always @(posedge clk)
    begin
        cipher_t exp_c;
        cipher_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.c1 = {first_coef3, first_coef2, first_coef1, first_coef0};
            got.c2 = {second_coef3, second_coef2, second_coef1, second_coef0};
            if (pending_cipher.size() == 0)
            begin
                $display("%0t: unexpected result transaction, c1 %h c2 %h",
                         $time, got.c1, got.c2);
                errors++;
            end
            else
            begin
                exp_c = pending_cipher.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got.c1[i] !== exp_c.c1[i])
                    begin
                        $display("%0t: first_coef%0d expected %h actual %h",
                                 $time, i, exp_c.c1[i], got.c1[i]);
                        errors++;
                    end
                    if (got.c2[i] !== exp_c.c2[i])
                    begin
                        $display("%0t: second_coef%0d expected %h actual %h",
                                 $time, i, exp_c.c2[i], got.c2[i]);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver stalls in short bursts.
    always @(posedge clk)
    begin
        if (!idle_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LimitCycles)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [12];
        cipher_t  c;
        int       eff;
        int       count;
        int       kind;
        logic [2:0] deg;

        // Under reset settings (p = 65521, n = 1, g = k = 1): c1 = 1, c2 = m0 mod p.
        rows[0]  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                     '{c1: 64'd1, c2: 64'd0}};
        rows[1]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                     '{c1: 64'd1, c2: 64'd14}};
        rows[2]  = '{16'd65521, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 1'b1,
                     '{c1: 64'd1, c2: 64'd0}};
        rows[3]  = '{16'd65520, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                     '{c1: 64'd1, c2: 64'd65520}};
        rows[4]  = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1,
                     '{c1: 64'd1, c2: 64'd1}};
        rows[5]  = '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 1'b0, '0};
        rows[6]  = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 1'b0, '0};
        rows[7]  = '{16'h1234, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 1'b0, '0};
        rows[8]  = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0, '0};
        rows[9]  = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFE, 1'b0, '0};
        rows[10] = '{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0002, 1'b0, '0};
        rows[11] = '{16'hFFF0, 16'h000F, 16'hF00F, 16'h0FF0, 16'h0003, 1'b0, '0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            send_msg(rows[r].m0, rows[r].m1, rows[r].m2, rows[r].m3, rows[r].e,
                     rows[r].typed, rows[r].c);
        drain();

        kind = 0;
        while (sent < ItemTarget)
        begin
            // The first phases force the corner settings, then all is random.
            deg = ($urandom_range(0, 5) < 4) ? 3'd1 : 3'($urandom);
            apb_write(gfel_pkg::RegPrime, {48'd0, rand_prime()});
            apb_write(gfel_pkg::RegTail, rand_poly());
            apb_write(gfel_pkg::RegGen, rand_poly());
            apb_write(gfel_pkg::RegPubKey, rand_poly());
            case (kind)
                0: apb_write(gfel_pkg::RegPrime, 64'd0);
                1: apb_write(gfel_pkg::RegPrime, 64'd1);
                2: apb_write(gfel_pkg::RegPrime, 64'hFFFF_FFFF_FFFF_FFFF);
                3: deg = 3'd0;
                4: deg = 3'd7;
                5: deg = 3'd4;
                6: apb_write(gfel_pkg::reg_idx_t'(5), {$urandom, $urandom});
                7: apb_write(gfel_pkg::reg_idx_t'(7), {$urandom, $urandom});
                8: apb_write(gfel_pkg::RegPrime, 64'd2);
                9: deg = 3'd2;
                10: deg = 3'd3;
                default: ;
            endcase
            apb_write(gfel_pkg::RegDegree, {$urandom, 29'($urandom), deg});
            @(posedge clk);
            eff = (sh_degree == 0) ? 1
                : (sh_degree > gfel_pkg::MaxDeg) ? gfel_pkg::MaxDeg : int'(sh_degree);
            count = (eff == 1) ? 24 : (eff == 2) ? 8 : (eff == 3) ? 4 : 3;
            for (int i = 0; i < count; i++)
            begin
                logic [15:0] e;
                case ($urandom_range(0, 7))
                    0: e = 16'h0000;
                    1: e = 16'hFFFF;
                    2: e = 16'h0001;
                    default: e = 16'($urandom);
                endcase
                c = '0;
                send_msg(rand_coef(), rand_coef(), rand_coef(), rand_coef(), e, 1'b0, c);
            end
            drain();
            kind++;
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/gfel_pkg.sv
hdl/gf_pn_elgamal_encrypt_unit.sv
hdl/gfel_checker.sv
tb/sv/gf_pn_elgamal_encrypt_unit_tb.sv
